### sv/qfl_pkg.sv
// ============================================================================
// qfl_pkg
// Shared types and constants for the quadrilateral footprint lookup block.
// ============================================================================
package qfl_pkg;

    localparam int ACTIVE_W = 9;
    localparam int FIELD_W  = 9;
    localparam int LIMIT_W  = 32;

    localparam logic [1:0] REQ_QUERY  = 2'd0;
    localparam logic [1:0] REQ_CORNER = 2'd1;
    localparam logic [1:0] REQ_FIELD  = 2'd2;
    localparam logic [1:0] REQ_LIMITS = 2'd3;

    localparam logic [2:0] PHASE_FIRST_EDGE = 3'd1;
    localparam logic [2:0] PHASE_WRAP       = 3'd4;

    typedef struct packed {
        logic [1:0]                req_type;
        logic [7:0]                slot;
        logic [1:0]                corner;
        logic signed [31:0]        coord_x;
        logic signed [31:0]        coord_y;
        logic [FIELD_W-1:0]        field_number;
        logic signed [LIMIT_W-1:0] first_limit;
        logic signed [LIMIT_W-1:0] second_limit;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0]        match_field;
        logic signed [LIMIT_W-1:0] match_first_limit;
        logic signed [LIMIT_W-1:0] match_second_limit;
    } t_out_item;

    typedef struct packed {
        logic first_edge;
        logic last_edge;
        logic last_quad;
    } t_edge_tag;

    typedef struct packed {
        logic valid;
        logic enclosed;
        logic last_quad;
    } t_edge_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIELD,
        ST_LIMIT,
        ST_OUT
    } t_state;

endpackage

### sv/qfl_edge_unit.sv
// ============================================================================
// qfl_edge_unit
// Pipelined edge test: one quad edge per cycle, exact cross-product side test
// with half-open crossing rule, and winding accumulation per quad.
// ============================================================================
module qfl_edge_unit #(
    parameter int COORD_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_flush,
    input  logic                         i_vld,
    input  qfl_pkg::t_edge_tag           i_tag,
    input  logic [2*COORD_BITS-1:0]      i_start,
    input  logic [2*COORD_BITS-1:0]      i_end,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    output qfl_pkg::t_edge_res           o_res
);
    import qfl_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic signed [COORD_BITS-1:0] xs, ys, xe, ye;

    logic                 r_s1_vld;
    t_edge_tag            r_s1_tag;
    logic signed [DW-1:0] r_dx, r_dpy, r_dpx, r_dy;
    logic                 r_s1_lo, r_s1_hi;

    logic                 r_s2_vld;
    t_edge_tag            r_s2_tag;
    logic signed [PW-1:0] r_p, r_q;
    logic                 r_s2_lo, r_s2_hi;

    logic signed [3:0] r_wind;
    logic signed [3:0] wind_base, delta, n_wind;
    t_edge_res         r_res;

    assign xs = i_start[COORD_BITS-1:0];
    assign ys = i_start[2*COORD_BITS-1:COORD_BITS];
    assign xe = i_end[COORD_BITS-1:0];
    assign ye = i_end[2*COORD_BITS-1:COORD_BITS];

    always_ff @(posedge i_clk) begin
        r_s1_tag <= i_tag;
        r_dx     <= DW'(xe) - DW'(xs);
        r_dpy    <= DW'(i_py) - DW'(ys);
        r_dpx    <= DW'(i_px) - DW'(xs);
        r_dy     <= DW'(ye) - DW'(ys);
        r_s1_lo  <= (ys <= i_py);
        r_s1_hi  <= (ye > i_py);

        r_s2_tag <= r_s1_tag;
        r_p      <= r_dx * r_dpy;
        r_q      <= r_dpx * r_dy;
        r_s2_lo  <= r_s1_lo;
        r_s2_hi  <= r_s1_hi;
    end

    always_comb begin
        wind_base = r_s2_tag.first_edge ? 4'sd0 : r_wind;
        delta     = 4'sd0;
        if (r_s2_lo && r_s2_hi && (r_p > r_q)) begin
            delta = 4'sd1;
        end else if (!r_s2_lo && !r_s2_hi && (r_p < r_q)) begin
            delta = -4'sd1;
        end
        n_wind = wind_base + delta;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_wind   <= 4'sd0;
            r_res    <= '0;
        end else begin
            r_s1_vld        <= i_vld && !i_flush;
            r_s2_vld        <= r_s1_vld && !i_flush;
            if (r_s2_vld) begin
                r_wind <= n_wind;
            end
            r_res.valid     <= r_s2_vld && r_s2_tag.last_edge && !i_flush;
            r_res.enclosed  <= (n_wind != 4'sd0);
            r_res.last_quad <= r_s2_tag.last_quad;
        end
    end

    assign o_res = r_res;

endmodule

### sv/quad_footprint_lookup_core.sv
// ============================================================================
// quad_footprint_lookup_core
// Quadrilateral footprint table with point lookup by exact winding number.
// ============================================================================
// A load beat (corner, field number or limits) is written in the cycle it is
// accepted and busy stays low. A query beat raises busy while footprints
// 0 .. n-1 (active_fields capped at MAX_FIELDS) are scanned in order through
// one edge unit fed from a corner memory with one read port; each footprint
// is issued as four corner reads and the closing edge. A query strobes the
// field and limits of the first footprint enclosing the point; a miss
// strobes a zero result after the last footprint, or in the cycle after
// acceptance when n is zero. The result beat is shown for exactly one cycle
// and cannot be held off, so the receiver must take it when o_strobe is high.
// ============================================================================
module quad_footprint_lookup_core #(
    parameter int MAX_FIELDS = 256,
    parameter int MAX_LIMITS = 256,
    parameter int COORD_BITS = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  qfl_pkg::t_in_item               i_item,
    input  logic                            i_cfg_we,
    input  logic [qfl_pkg::ACTIVE_W-1:0]    i_cfg_wdata,
    output logic                            o_strobe,
    output qfl_pkg::t_out_item              o_result
);
    import qfl_pkg::*;

    localparam int FIW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
    localparam int LIW = (MAX_LIMITS > 1) ? $clog2(MAX_LIMITS) : 1;
    localparam int FCW = $clog2(MAX_FIELDS + 1);
    localparam int CW  = 2 * COORD_BITS;

    logic [CW-1:0]            r_corner_mem [MAX_FIELDS*4];
    logic [FIELD_W-1:0]       r_field_mem  [MAX_FIELDS];
    logic [2*LIMIT_W-1:0]     r_limit_mem  [MAX_LIMITS];

    t_state                   r_state, n_state;
    logic [ACTIVE_W-1:0]      r_active, n_active;
    logic [FCW-1:0]           r_quad, n_quad;
    logic [2:0]               r_phase, n_phase;
    logic                     r_issue, n_issue;
    logic [FCW-1:0]           r_scan_n, n_scan_n;
    logic [FCW-1:0]           r_res_quad, n_res_quad;
    logic [FIW-1:0]           r_hit, n_hit;
    logic                     r_rd_vld, n_rd_vld;
    logic [2:0]               r_rd_phase, n_rd_phase;
    logic                     r_rd_last, n_rd_last;
    logic                     r_strobe, n_strobe;
    t_out_item                r_out, n_out;

    logic signed [COORD_BITS-1:0] r_px, r_py;
    logic [CW-1:0]            r_cdat, r_c0, r_prev;
    logic [FIELD_W-1:0]       r_fdat;
    logic [2*LIMIT_W-1:0]     r_ldat;

    logic                     accept;
    logic                     query_in;
    logic [FCW-1:0]           scan_n_in;
    logic                     issue_last;
    logic                     flush;
    logic                     field_slot_ok, limit_slot_ok;
    logic [FIW+1:0]           rd_addr;
    logic [LIW-1:0]           lim_addr;
    logic                     lim_ok;
    logic                     edge_vld;
    t_edge_tag                edge_tag;
    logic [CW-1:0]            edge_end;
    t_edge_res                edge_res;

    assign accept        = start && !busy;
    assign query_in      = accept && (i_item.req_type == REQ_QUERY);
    assign field_slot_ok = (32'(i_item.slot) < MAX_FIELDS);
    assign limit_slot_ok = (32'(i_item.slot) < MAX_LIMITS);
    assign scan_n_in     = (32'(r_active) < MAX_FIELDS) ? FCW'(r_active) : FCW'(MAX_FIELDS);
    assign issue_last    = (FCW'(r_quad + 1'b1) == r_scan_n);
    assign rd_addr       = {r_quad[FIW-1:0], r_phase[1:0]};
    assign lim_addr      = LIW'(r_fdat - 9'd1);
    assign lim_ok        = (r_fdat != '0) && (32'(r_fdat) <= MAX_LIMITS);

    always_ff @(posedge i_clk) begin
        if (accept && (i_item.req_type == REQ_CORNER) && field_slot_ok) begin
            r_corner_mem[{FIW'(i_item.slot), i_item.corner}] <=
                {i_item.coord_y[COORD_BITS-1:0], i_item.coord_x[COORD_BITS-1:0]};
        end
        r_cdat <= r_corner_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_item.req_type == REQ_FIELD) && field_slot_ok) begin
            r_field_mem[FIW'(i_item.slot)] <= i_item.field_number;
        end
        r_fdat <= r_field_mem[r_hit];
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_item.req_type == REQ_LIMITS) && limit_slot_ok) begin
            r_limit_mem[LIW'(i_item.slot)] <= {i_item.second_limit, i_item.first_limit};
        end
        r_ldat <= r_limit_mem[lim_addr];
    end

    assign edge_vld            = r_rd_vld && (r_rd_phase != 3'd0);
    assign edge_tag.first_edge = (r_rd_phase == PHASE_FIRST_EDGE);
    assign edge_tag.last_edge  = (r_rd_phase == PHASE_WRAP);
    assign edge_tag.last_quad  = r_rd_last;
    assign edge_end            = (r_rd_phase == PHASE_WRAP) ? r_c0 : r_cdat;

    qfl_edge_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flush (flush),
        .i_vld   (edge_vld),
        .i_tag   (edge_tag),
        .i_start (r_prev),
        .i_end   (edge_end),
        .i_px    (r_px),
        .i_py    (r_py),
        .o_res   (edge_res)
    );

    always_ff @(posedge i_clk) begin
        if (query_in) begin
            r_px <= i_item.coord_x[COORD_BITS-1:0];
            r_py <= i_item.coord_y[COORD_BITS-1:0];
        end
        if (r_rd_vld && (r_rd_phase == 3'd0)) begin
            r_c0 <= r_cdat;
        end
        if (r_rd_vld) begin
            r_prev <= r_cdat;
        end
        r_out <= n_out;
    end

    always_comb begin
        n_state    = r_state;
        n_active   = i_cfg_we ? i_cfg_wdata : r_active;
        n_quad     = r_quad;
        n_phase    = r_phase;
        n_issue    = r_issue;
        n_scan_n   = r_scan_n;
        n_res_quad = r_res_quad;
        n_hit      = r_hit;
        n_rd_vld   = 1'b0;
        n_rd_phase = r_phase;
        n_rd_last  = issue_last;
        n_strobe   = 1'b0;
        n_out      = r_out;
        flush      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (query_in) begin
                    n_quad     = '0;
                    n_phase    = 3'd0;
                    n_res_quad = '0;
                    n_scan_n   = scan_n_in;
                    if (scan_n_in == '0) begin
                        n_strobe = 1'b1;
                        n_out    = '0;
                    end else begin
                        n_state = ST_SCAN;
                        n_issue = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (r_issue) begin
                    n_rd_vld = 1'b1;
                    if (r_phase == PHASE_WRAP) begin
                        n_phase = 3'd0;
                        n_quad  = FCW'(r_quad + 1'b1);
                        if (issue_last) begin
                            n_issue = 1'b0;
                        end
                    end else begin
                        n_phase = r_phase + 3'd1;
                    end
                end
                if (edge_res.valid) begin
                    n_res_quad = FCW'(r_res_quad + 1'b1);
                    if (edge_res.enclosed) begin
                        n_hit    = FIW'(r_res_quad);
                        n_state  = ST_FIELD;
                        flush    = 1'b1;
                        n_rd_vld = 1'b0;
                    end else if (edge_res.last_quad) begin
                        n_state  = ST_IDLE;
                        n_strobe = 1'b1;
                        n_out    = '0;
                        flush    = 1'b1;
                        n_rd_vld = 1'b0;
                    end
                end
            end
            ST_FIELD: begin
                n_state = ST_LIMIT;
            end
            ST_LIMIT: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                n_state                  = ST_IDLE;
                n_strobe                 = 1'b1;
                n_out.match_field        = r_fdat;
                n_out.match_first_limit  = lim_ok ? r_ldat[LIMIT_W-1:0] : '0;
                n_out.match_second_limit = lim_ok ? r_ldat[2*LIMIT_W-1:LIMIT_W] : '0;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_active   <= '0;
            r_quad     <= '0;
            r_phase    <= 3'd0;
            r_issue    <= 1'b0;
            r_scan_n   <= '0;
            r_res_quad <= '0;
            r_hit      <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_phase <= 3'd0;
            r_rd_last  <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_active   <= n_active;
            r_quad     <= n_quad;
            r_phase    <= n_phase;
            r_issue    <= n_issue;
            r_scan_n   <= n_scan_n;
            r_res_quad <= n_res_quad;
            r_hit      <= n_hit;
            r_rd_vld   <= n_rd_vld;
            r_rd_phase <= n_rd_phase;
            r_rd_last  <= n_rd_last;
            r_strobe   <= n_strobe;
        end
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

### sv/qfl_checker.sv
// ============================================================================
// qfl_checker
// Port-level checks on the footprint lookup block, bound to the top level.
// ============================================================================
module qfl_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input qfl_pkg::t_in_item    i_item,
    input logic                 o_strobe,
    input qfl_pkg::t_out_item   o_result
);
    import qfl_pkg::*;

    logic query_acc, load_acc;

    assign query_acc = start && !busy && (i_item.req_type == REQ_QUERY);
    assign load_acc  = start && !busy && (i_item.req_type != REQ_QUERY);

    a_strobe_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat shown while busy");

    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        query_acc |=> (busy || o_strobe))
        else $error("query beat neither started a scan nor answered");

    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_acc |=> (!busy && !o_strobe))
        else $error("load beat raised busy or produced a result");

    a_no_match_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.match_field == '0)) |->
        ((o_result.match_first_limit == '0) && (o_result.match_second_limit == '0)))
        else $error("no-match result carries nonzero limits");

    a_busy_ends_in_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(busy) && !busy) |-> o_strobe)
        else $error("scan ended without a result beat");

endmodule

bind quad_footprint_lookup_core qfl_checker u_qfl_checker (.*);
